/* hw/rtl/dpm_pkg.sv */
package dpm_pkg;

  localparam int unsigned WordWidth = 64;
  localparam int unsigned ExpWidth  = 11;
  localparam int unsigned FracWidth = 52;
  localparam int unsigned SigWidth  = FracWidth + 1;
  localparam int unsigned ProdWidth = 2 * SigWidth;

  localparam logic [ExpWidth-1:0]  ExpMax   = 11'h7FF;
  localparam logic [WordWidth-1:0] InfBits  = 64'h7FF0000000000000;
  localparam logic [WordWidth-1:0] QnanBits = 64'h7FF8000000000000;

  // Exponent bias: one of the two is subtracted from the sum once the product's top bit is known.
  localparam logic [ExpWidth+1:0] BiasHigh = 13'd1022;
  localparam logic [ExpWidth+1:0] BiasLow  = 13'd1023;

  // Early result class decided from the operands alone.
  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_ZERO,
    CLS_INF,
    CLS_NAN
  } cls_t;

  // Control that travels with one transaction between stages.
  typedef struct packed {
    logic                sign;
    cls_t                cls;
    logic [ExpWidth:0]   exp_sum;
  } ctl_t;

endpackage

/* hw/rtl/dpm_mul53.sv */
// 53 x 53 significand product in a three stage pipeline built from
// four partial products of at most 27 x 27 bits.
module dpm_mul53 (
  input  logic                         clk,
  input  logic [2:0]                   en,
  input  logic [dpm_pkg::SigWidth-1:0] sig_a,
  input  logic [dpm_pkg::SigWidth-1:0] sig_b,
  output logic [dpm_pkg::ProdWidth-1:0] prod
);
  import dpm_pkg::*;

  localparam int unsigned LoW = 27;
  localparam int unsigned HiW = SigWidth - LoW;

  logic [2*LoW-1:0]   pp_ll;
  logic [LoW+HiW-1:0] pp_lh;
  logic [LoW+HiW-1:0] pp_hl;
  logic [2*HiW-1:0]   pp_hh;
  logic [ProdWidth-1:0] part_lo;
  logic [ProdWidth-1:0] part_hi;

  // Stage one: partial products.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll <= sig_a[LoW-1:0] * sig_b[LoW-1:0];
      pp_lh <= sig_a[LoW-1:0] * sig_b[SigWidth-1:LoW];
      pp_hl <= sig_a[SigWidth-1:LoW] * sig_b[LoW-1:0];
      pp_hh <= sig_a[SigWidth-1:LoW] * sig_b[SigWidth-1:LoW];
    end
  end

  // Stage two: pair the partial products.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      part_lo <= ProdWidth'(pp_ll) + (ProdWidth'(pp_lh) << LoW);
      part_hi <= (ProdWidth'(pp_hh) << (2 * LoW)) + (ProdWidth'(pp_hl) << LoW);
    end
  end

  // Stage three: final sum.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod <= part_lo + part_hi;
    end
  end

endmodule

/* hw/rtl/double_precision_multiplier.sv */
// Channel | Signals                          | Direction
// in      | in_valid, in_stall, operand_a/b  | operand pair enters
// out     | out_valid, out_stall, product_bits | product leaves
//
// One transaction enters every cycle while in_stall is low; its product passes through
// the three multiplier stages, a rounding stage and the output register.
// Reset clears only the valid bits of the stages; data registers are not reset.
// A stall holds a full stage; bubbles ahead of it still fill, so nothing is lost.
module double_precision_multiplier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dpm_pkg::WordWidth-1:0] operand_a,
  input  logic [dpm_pkg::WordWidth-1:0] operand_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dpm_pkg::WordWidth-1:0] product_bits
);
  import dpm_pkg::*;

  localparam int unsigned Stages = 5;

  logic [Stages-1:0] vld;
  logic [Stages-1:0] en;
  ctl_t ctl [0:3];
  ctl_t ctl_in;

  logic [ExpWidth-1:0]  ea, eb;
  logic [FracWidth-1:0] fa, fb;
  logic za, zb, nan_in, inf_in, den_in;
  logic [ProdWidth-1:0] prod;

  // Per-stage enable: a stage moves when it is empty or the next one moves.
  always_comb begin
    en[Stages-1] = !vld[Stages-1] || !out_stall;
    for (int i = Stages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = Stages - 1; i > 0; i--) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
      if (en[0]) vld[0] <= in_valid;
    end
  end

  // Operand classification.
  always_comb begin
    ea = operand_a[WordWidth-2 -: ExpWidth];
    eb = operand_b[WordWidth-2 -: ExpWidth];
    fa = operand_a[FracWidth-1:0];
    fb = operand_b[FracWidth-1:0];
    za = (ea == '0) && (fa == '0);
    zb = (eb == '0) && (fb == '0);
    nan_in = ((ea == ExpMax) && (fa != '0)) || ((eb == ExpMax) && (fb != '0));
    inf_in = (ea == ExpMax) || (eb == ExpMax);
    den_in = (ea == '0) || (eb == '0);
    ctl_in.sign    = operand_a[WordWidth-1] ^ operand_b[WordWidth-1];
    ctl_in.exp_sum = {1'b0, ea} + {1'b0, eb};
    if (nan_in || (inf_in && (za || zb))) begin
      ctl_in.cls = CLS_NAN;
    end else if (inf_in) begin
      ctl_in.cls = CLS_INF;
    end else if (den_in) begin
      ctl_in.cls = CLS_ZERO;
    end else begin
      ctl_in.cls = CLS_NORMAL;
    end
  end

  // Control travels alongside the multiplier stages and stage four.
  always_ff @(posedge clk) begin
    if (en[0]) ctl[0] <= ctl_in;
    for (int i = 1; i < 4; i++) begin
      if (en[i]) ctl[i] <= ctl[i-1];
    end
  end

  dpm_mul53 u_mul (
    .clk   (clk),
    .en    (en[2:0]),
    .sig_a ({1'b1, fa}),
    .sig_b ({1'b1, fb}),
    .prod  (prod)
  );

  // Normalize and compute round bits from the finished product.
  logic                 top;
  logic [ExpWidth+1:0]  e_pre;
  logic [SigWidth-1:0]  man;
  logic                 rnd, stk;
  logic                 uf, of;

  always_comb begin
    top   = prod[ProdWidth-1];
    e_pre = {1'b0, ctl[2].exp_sum} - (top ? BiasHigh : BiasLow);
    if (top) begin
      man = prod[ProdWidth-1 -: SigWidth];
      rnd = prod[SigWidth-1];
      stk = |prod[SigWidth-2:0];
    end else begin
      man = prod[ProdWidth-2 -: SigWidth];
      rnd = prod[SigWidth-2];
      stk = |prod[SigWidth-3:0];
    end
    uf = e_pre[ExpWidth+1] || (e_pre == '0);
    of = !uf && (e_pre[ExpWidth:0] >= {1'b0, ExpMax});
  end

  // Stage four: register the normalized significand and flags.
  logic [SigWidth-1:0]  man_r;
  logic [ExpWidth-1:0]  e_r;
  logic                 inc_r, uf_r, of_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      man_r <= man;
      e_r   <= e_pre[ExpWidth-1:0];
      inc_r <= rnd && (stk || man[0]);
      uf_r  <= uf;
      of_r  <= of;
    end
  end

  // Stage five: round and pack.
  logic [SigWidth:0]    man_rd;
  logic [ExpWidth:0]    e_rd;
  logic [FracWidth-1:0] frac_o;
  logic [WordWidth-1:0] res;

  always_comb begin
    man_rd = {1'b0, man_r} + (SigWidth + 1)'(inc_r);
    e_rd   = {1'b0, e_r};
    frac_o = man_rd[FracWidth-1:0];
    if (man_rd[SigWidth]) begin
      e_rd   = e_rd + 1'b1;
      frac_o = man_rd[FracWidth:1];
    end
    case (ctl[3].cls)
      CLS_NAN:  res = QnanBits;
      CLS_INF:  res = {ctl[3].sign, InfBits[WordWidth-2:0]};
      CLS_ZERO: res = {ctl[3].sign, {(WordWidth-1){1'b0}}};
      CLS_NORMAL: begin
        if (uf_r) begin
          res = {ctl[3].sign, {(WordWidth-1){1'b0}}};
        end else if (of_r || (e_rd >= {1'b0, ExpMax})) begin
          res = {ctl[3].sign, InfBits[WordWidth-2:0]};
        end else begin
          res = {ctl[3].sign, e_rd[ExpWidth-1:0], frac_o};
        end
      end
      default: res = QnanBits;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) product_bits <= res;
  end

  // A full output stage that is stalled keeps its valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped under stall");

  // The input is stalled only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld == {Stages{1'b1}}))
    else $error("input stalled with a free stage");

  // A NaN class always leaves as the canonical quiet NaN.
  a_nan_out: assert property (@(posedge clk) disable iff (rst)
    en[4] && vld[3] && (ctl[3].cls == CLS_NAN) |=> product_bits == QnanBits)
    else $error("NaN class produced non-canonical result");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import dpm_pkg::*;

  localparam int unsigned RandomItems = 1300;
  localparam int unsigned CycleLimit  = 400000;

  // Expected products, oldest first, and the mismatch count.
  class product_scoreboard;
    logic [WordWidth-1:0] pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Product of two binary64 patterns: round to nearest even, flush to zero.
    function automatic logic [WordWidth-1:0] fmul(logic [WordWidth-1:0] a,
                                                  logic [WordWidth-1:0] b);
      logic                 s;
      logic [ExpWidth-1:0]  ea, eb;
      logic [FracWidth-1:0] fa, fb;
      logic [ProdWidth-1:0] prod;
      logic [SigWidth:0]    sig;
      logic                 top, guard, sticky;
      int                   e;
      s  = a[63] ^ b[63];
      ea = a[62:52];
      eb = b[62:52];
      fa = a[51:0];
      fb = b[51:0];
      if ((ea == ExpMax && fa != 0) || (eb == ExpMax && fb != 0)) return QnanBits;
      if (ea == ExpMax || eb == ExpMax) begin
        if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) return QnanBits;
        return {s, 63'd0} | InfBits;
      end
      if (ea == 0 || eb == 0) return {s, 63'd0};
      prod = {1'b1, fa} * {1'b1, fb};
      top  = prod[ProdWidth-1];
      e    = int'(ea) + int'(eb) - (top ? 1022 : 1023);
      if (e <= 0) return {s, 63'd0};
      if (e >= 2047) return {s, 63'd0} | InfBits;
      if (top) begin
        sig    = {1'b0, prod[105:53]};
        guard  = prod[52];
        sticky = |prod[51:0];
      end else begin
        sig    = {1'b0, prod[104:52]};
        guard  = prod[51];
        sticky = |prod[50:0];
      end
      if (guard && (sticky || sig[0])) begin
        sig = sig + 1'b1;
        if (sig[SigWidth]) begin
          sig = sig >> 1;
          e++;
          if (e >= 2047) return {s, 63'd0} | InfBits;
        end
      end
      return {s, e[10:0], sig[51:0]};
    endfunction

    function void note_operands(logic [WordWidth-1:0] a, logic [WordWidth-1:0] b);
      pending.push_back(fmul(a, b));
    endfunction

    function void check_product(logic [WordWidth-1:0] got);
      logic [WordWidth-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected product %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $display("%0t: product_bits expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [WordWidth-1:0] operand_a;
  logic [WordWidth-1:0] operand_b;
  logic                 out_valid;
  logic                 out_stall;
  logic [WordWidth-1:0] product_bits;

  product_scoreboard sb;
  int unsigned cycles;
  bit          stim_done;

  double_precision_multiplier dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .product_bits(product_bits)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length: mostly zero or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random operand that favors edge exponents and fractions.
  function automatic logic [WordWidth-1:0] rand_operand();
    logic [ExpWidth-1:0]  ex;
    logic [FracWidth-1:0] fr;
    int unsigned          pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       ex = '0;
      1:       ex = ExpMax;
      2:       ex = ExpWidth'($urandom_range(1, 20));
      3:       ex = ExpWidth'($urandom_range(2030, 2046));
      default: ex = ExpWidth'($urandom_range(400, 1650));
    endcase
    fr = FracWidth'({$urandom, $urandom});
    pick = $urandom_range(0, 9);
    if (pick == 0) fr = '0;
    else if (pick == 1) fr = '1;
    return {$urandom_range(0, 1) == 1, ex, fr};
  endfunction

  // Offer one pair and hold it until accepted; valid drops only across a gap.
  task automatic send_pair(logic [WordWidth-1:0] a, logic [WordWidth-1:0] b);
    int unsigned idle;
    idle = gap_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_operands(a, b);
  endtask

  // Directed corner pairs.
  task automatic run_directed();
    logic [WordWidth-1:0] one, two, maxn, minn, sub, inf, nan, snan;
    one  = 64'h3FF0000000000000;
    two  = 64'h4000000000000000;
    maxn = 64'h7FEFFFFFFFFFFFFF;
    minn = 64'h0010000000000000;
    sub  = 64'h000FFFFFFFFFFFFF;
    inf  = InfBits;
    nan  = 64'hFFF0000000000001;
    snan = 64'h7FF4000000000000;
    send_pair(one, two);
    send_pair(64'hBFF0000000000000, two);
    send_pair(nan, one);
    send_pair(one, snan);
    send_pair(inf, 64'd0);
    send_pair(64'h8000000000000000, inf);
    send_pair(inf, sub);
    send_pair(inf, 64'hC000000000000000);
    send_pair(inf, inf);
    send_pair(sub, two);
    send_pair(64'd0, maxn);
    send_pair(minn, minn);
    send_pair(minn, 64'h3FE0000000000000);
    send_pair(minn, one);
    send_pair(maxn, maxn);
    send_pair(maxn, one);
    send_pair(maxn, 64'h3FF0000000000001);
    send_pair(64'h3FFFFFFFFFFFFFFF, 64'h3FFFFFFFFFFFFFFF);
    send_pair(64'h3FF0000000000001, 64'h3FF8000000000000);
    send_pair(64'h3FF0000000000003, 64'h3FF8000000000000);
    send_pair(64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000);
    send_pair(64'h7FEFFFFFFFFFFFFF, 64'h3FF0000000000000);
    send_pair(64'h001FFFFFFFFFFFFF, 64'h3FE0000000000000);
  endtask

  // Sender.
  initial begin
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    operand_a = '0;
    operand_b = '0;
    stim_done = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 9) == 0) send_pair({$urandom, $urandom}, {$urandom, $urandom});
      else send_pair(rand_operand(), rand_operand());
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off so the pipe fills.
  initial begin
    int unsigned hold;
    int unsigned stall_len;
    out_stall = 1'b1;
    @(negedge rst);
    repeat (60) @(posedge clk);
    hold = 0;
    while (hold < 40) begin
      @(posedge clk);
      hold++;
    end
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      stall_len = gap_len();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Check each accepted product transaction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_product(product_bits);
  end

  // Completion and timeout.
  initial begin
    cycles = 0;
    @(negedge rst);
    while (!(stim_done && sb.pending.size() == 0) && cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles < CycleLimit) begin
      repeat (20) @(posedge clk);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/dpm_pkg.sv
hw/rtl/dpm_mul53.sv
hw/rtl/double_precision_multiplier.sv
sim/tb.sv
